/* rtl/core/spq_pkg.sv */
// Shared types and constants for the sorted priority queue.
`default_nettype none

package spq_pkg;

  localparam int DEPTH = 64;
  localparam int KEY_W = 16;
  localparam int TAG_W = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [2:0] FUNC_OFFER = 3'd0;
  localparam logic [2:0] FUNC_PEEK = 3'd1;
  localparam logic [2:0] FUNC_POLL = 3'd2;
  localparam logic [2:0] FUNC_READ = 3'd3;
  localparam logic [2:0] FUNC_RMTAG = 3'd4;
  localparam logic [2:0] FUNC_RMIDX = 3'd5;

  localparam logic REG_ORDER_MODE = 1'b0;

  typedef struct packed {
    logic [2:0]       func;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic [IDX_W-1:0] index;
  } req_t;

  typedef struct packed {
    logic             found;
    logic [KEY_W-1:0] out_key;
    logic [TAG_W-1:0] out_tag;
    logic [IDX_W-1:0] position;
    logic [CNT_W-1:0] removed_count;
    logic [CNT_W-1:0] count;
  } rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } entry_t;

  typedef enum logic [1:0] {
    HIT_RANK,
    HIT_INDEX,
    HIT_TAG
  } hit_mode_t;

  typedef enum logic [1:0] {
    ACT_HOLD,
    ACT_INSERT,
    ACT_DROP
  } act_t;

  typedef struct packed {
    hit_mode_t        hit_mode;
    act_t             act;
    logic             mode;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic [IDX_W-1:0] index;
    logic [CNT_W-1:0] count;
  } cell_ctrl_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage

`default_nettype wire

/* rtl/core/spq_cell.sv */
// One queue slot: holds an entry, matches it and shifts with its neighbors.
`default_nettype none

module spq_cell (
  input  logic                            clk,
  input  spq_pkg::cell_ctrl_t             ctrl,
  input  logic [spq_pkg::IDX_W-1:0]       slot,
  input  spq_pkg::entry_t                 left,
  input  spq_pkg::entry_t                 right,
  input  logic                            seen_in,
  output logic                            seen_out,
  output spq_pkg::entry_t                 held,
  output spq_pkg::entry_t                 pick
);

  localparam int CW = spq_pkg::CNT_W;

  spq_pkg::entry_t  ent;
  spq_pkg::entry_t  ent_next;
  logic [CW-1:0]    slot_ext;
  logic             occupied;
  logic             outranks;
  logic             hit;
  logic             first;

  assign slot_ext = CW'(slot);
  assign occupied = slot_ext < ctrl.count;
  assign outranks = ctrl.mode ? (ctrl.key > ent.key) : (ctrl.key < ent.key);

  always_comb begin
    unique case (ctrl.hit_mode)
      spq_pkg::HIT_RANK:  hit = occupied ? outranks : (slot_ext == ctrl.count);
      spq_pkg::HIT_INDEX: hit = occupied && (slot == ctrl.index);
      spq_pkg::HIT_TAG:   hit = occupied && (ent.tag == ctrl.tag);
      default:            hit = 1'b0;
    endcase
  end

  assign first = hit && !seen_in;
  assign seen_out = seen_in || hit;
  assign pick = first ? ent : '0;
  assign held = ent;

  always_comb begin
    ent_next = ent;
    unique case (ctrl.act)
      spq_pkg::ACT_INSERT: begin
        if (first) begin
          ent_next.key = ctrl.key;
          ent_next.tag = ctrl.tag;
        end else if (seen_in) begin
          ent_next = left;
        end
      end
      spq_pkg::ACT_DROP: begin
        if (seen_out) begin
          ent_next = right;
        end
      end
      default: ent_next = ent;
    endcase
  end

  always_ff @(posedge clk) begin
    ent <= ent_next;
  end

endmodule

`default_nettype wire

/* rtl/core/sorted_priority_queue_core.sv */
// Sorted priority queue top level: request control and the row of slot cells.
//
//   channel | direction | handshake             | word
//   req     | in        | req_valid / req_ready | spq_pkg::req_t
//   rsp     | out       | rsp_valid / rsp_ready | spq_pkg::rsp_t
//   apb     | in        | psel, penable, pready | order_mode at byte address 0
//
// A word is accepted in the idle state, then runs through the cell row in the execute state.
// Remove by tag stays in execute while a match is left, one slot dropped per cycle.
// Reset clears the count, the result valid flag and order_mode; slots are not cleared.
// The execute cycle waits while a finished result is still held in the result register.
`default_nettype none

module sorted_priority_queue_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  spq_pkg::req_t                 req,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output spq_pkg::rsp_t                 rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [spq_pkg::ADDR_W-1:0]    paddr,
  input  logic [spq_pkg::DATA_W-1:0]    pwdata,
  output logic [spq_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  localparam int DEPTH = spq_pkg::DEPTH;
  localparam int IW = spq_pkg::IDX_W;
  localparam int CW = spq_pkg::CNT_W;
  localparam int DW = spq_pkg::DATA_W;

  spq_pkg::state_t      state;
  spq_pkg::state_t      state_next;
  spq_pkg::req_t        cur;
  logic [CW-1:0]        count;
  logic [CW-1:0]        count_next;
  logic [CW-1:0]        removed;
  logic [CW-1:0]        removed_next;
  logic                 order_mode;
  spq_pkg::rsp_t        rsp_next;
  logic                 finish;
  logic                 slot_free;
  logic                 any_hit;
  spq_pkg::cell_ctrl_t  ctrl;
  spq_pkg::entry_t      picked;
  logic [IW-1:0]        position;
  logic                 cfg_write;

  logic [DEPTH:0]       seen;
  spq_pkg::entry_t      held  [DEPTH];
  spq_pkg::entry_t      lefts [DEPTH];
  spq_pkg::entry_t      rights[DEPTH];
  spq_pkg::entry_t      picks [DEPTH];

  // configuration port
  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      order_mode <= 1'b0;
    end else if (cfg_write && (paddr[2] == spq_pkg::REG_ORDER_MODE)) begin
      order_mode <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == spq_pkg::REG_ORDER_MODE) ? DW'(order_mode) : '0;

  // cell row
  assign seen[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign lefts[i] = '0;
    end else begin : g_mid
      assign lefts[i] = held[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign rights[i] = '0;
    end else begin : g_body
      assign rights[i] = held[i+1];
    end

    spq_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .slot     (IW'(i)),
      .left     (lefts[i]),
      .right    (rights[i]),
      .seen_in  (seen[i]),
      .seen_out (seen[i+1]),
      .held     (held[i]),
      .pick     (picks[i])
    );
  end

  assign any_hit = seen[DEPTH];

  always_comb begin
    picked = '0;
    position = '0;
    for (int i = 0; i < DEPTH; i++) begin
      picked = picked | picks[i];
      if (seen[i+1] && !seen[i]) begin
        position = position | IW'(i);
      end
    end
  end

  // control
  assign slot_free = !rsp_valid || rsp_ready;
  assign req_ready = (state == spq_pkg::ST_IDLE);

  always_comb begin
    ctrl.mode = order_mode;
    ctrl.key = cur.key;
    ctrl.tag = cur.tag;
    ctrl.count = count;
    ctrl.index = cur.index;
    ctrl.hit_mode = spq_pkg::HIT_INDEX;
    ctrl.act = spq_pkg::ACT_HOLD;
    finish = 1'b0;
    unique case (cur.func) inside
      spq_pkg::FUNC_OFFER: ctrl.hit_mode = spq_pkg::HIT_RANK;
      spq_pkg::FUNC_RMTAG: ctrl.hit_mode = spq_pkg::HIT_TAG;
      spq_pkg::FUNC_PEEK, spq_pkg::FUNC_POLL: ctrl.index = '0;
      default: ctrl.hit_mode = spq_pkg::HIT_INDEX;
    endcase
    if (state == spq_pkg::ST_EXEC) begin
      unique case (cur.func) inside
        spq_pkg::FUNC_OFFER: begin
          finish = slot_free;
          if (slot_free && (count < CW'(DEPTH))) begin
            ctrl.act = spq_pkg::ACT_INSERT;
          end
        end
        spq_pkg::FUNC_POLL, spq_pkg::FUNC_RMIDX: begin
          finish = slot_free;
          if (slot_free && any_hit) begin
            ctrl.act = spq_pkg::ACT_DROP;
          end
        end
        spq_pkg::FUNC_RMTAG: begin
          if (any_hit) begin
            ctrl.act = spq_pkg::ACT_DROP;
          end else begin
            finish = slot_free;
          end
        end
        default: finish = slot_free;
      endcase
    end
  end

  always_comb begin
    count_next = count;
    removed_next = removed;
    unique case (ctrl.act)
      spq_pkg::ACT_INSERT: count_next = count + CW'(1);
      spq_pkg::ACT_DROP: begin
        count_next = count - CW'(1);
        if (cur.func == spq_pkg::FUNC_RMTAG) begin
          removed_next = removed + CW'(1);
        end
      end
      default: count_next = count;
    endcase
  end

  always_comb begin
    rsp_next = '0;
    rsp_next.count = count_next;
    unique case (cur.func) inside
      spq_pkg::FUNC_OFFER: begin
        rsp_next.found = count < CW'(DEPTH);
        rsp_next.position = rsp_next.found ? position : '0;
      end
      spq_pkg::FUNC_PEEK, spq_pkg::FUNC_POLL, spq_pkg::FUNC_READ, spq_pkg::FUNC_RMIDX: begin
        rsp_next.found = any_hit;
        rsp_next.out_key = picked.key;
        rsp_next.out_tag = picked.tag;
      end
      spq_pkg::FUNC_RMTAG: begin
        rsp_next.found = removed != '0;
        rsp_next.removed_count = removed;
      end
      default: rsp_next.found = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      spq_pkg::ST_IDLE: if (req_valid) state_next = spq_pkg::ST_EXEC;
      spq_pkg::ST_EXEC: if (finish) state_next = spq_pkg::ST_IDLE;
      default: state_next = spq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spq_pkg::ST_IDLE;
      count <= '0;
      removed <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (req_valid && req_ready) begin
        removed <= '0;
      end else begin
        removed <= removed_next;
      end
      if (finish) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      cur <= req;
    end
    if (finish) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/spq_checker.sv */
// Port-level checks for the sorted priority queue, bound to the top level.
`default_nettype none

module spq_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input spq_pkg::rsp_t  rsp
);

  localparam int CW = spq_pkg::CNT_W;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result word changed while stalled");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.count <= CW'(spq_pkg::DEPTH))
    else $error("count beyond depth");

  a_removed_found: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.removed_count != '0) |-> rsp.found)
    else $error("removal without found");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.found |-> (rsp.out_key == '0) && (rsp.out_tag == '0)
                                && (rsp.position == '0))
    else $error("payload on a miss");

  a_one_word: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second word taken during execute");

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

`default_nettype wire
